>>> rtl/assert_macros.svh
// Shared assertion macros for the palette block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_CLK(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property that must never hold outside reset.
`define ASSERT_NEVER(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(prop)) else $error(msg);

`endif

>>> rtl/pnm_pkg.sv
`timescale 1ns / 1ps

package pnm_pkg;

   localparam int ROM_ROWS = 30;
   localparam int IDX_W    = 5;
   localparam int CH_W     = 8;
   localparam int SQ_W     = 16;
   localparam int DIST_W   = 18;

   localparam logic [DIST_W-1:0] NO_MATCH_DIST = DIST_W'(255 * 255 * 3 + 1);
   localparam logic [DIST_W-1:0] LIGHT_LIMIT   = DIST_W'(128 * 128 * 3);

   localparam logic [IDX_W-1:0] BLACK_IDX  = IDX_W'(0);
   localparam logic [IDX_W-1:0] DDGRAY_IDX = IDX_W'(1);

   typedef enum logic [1:0] {
      OP_NEAREST = 2'd0,
      OP_MIX     = 2'd1,
      OP_LIGHT   = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SCAN,
      ST_LIGHT,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [CH_W-1:0] b;
      logic [CH_W-1:0] g;
      logic [CH_W-1:0] r;
   } row_type;

   // Search pipeline control from the sequencer.
   typedef struct packed {
      logic             clear;
      logic             issue;
      logic [IDX_W-1:0] idx;
   } ctl_type;

   localparam row_type PALETTE [ROM_ROWS] = '{
      '{8'd0,   8'd0,   8'd0  }, '{8'd72,  8'd72,  8'd72 }, '{8'd132, 8'd132, 8'd132},
      '{8'd194, 8'd194, 8'd194}, '{8'd255, 8'd255, 8'd255}, '{8'd194, 8'd255, 8'd255},
      '{8'd72,  8'd0,   8'd0  }, '{8'd0,   8'd72,  8'd0  }, '{8'd72,  8'd72,  8'd0  },
      '{8'd0,   8'd0,   8'd72 }, '{8'd72,  8'd0,   8'd72 }, '{8'd0,   8'd72,  8'd72 },
      '{8'd132, 8'd0,   8'd0  }, '{8'd0,   8'd132, 8'd0  }, '{8'd132, 8'd132, 8'd0  },
      '{8'd0,   8'd0,   8'd132}, '{8'd132, 8'd0,   8'd132}, '{8'd0,   8'd132, 8'd132},
      '{8'd194, 8'd0,   8'd0  }, '{8'd0,   8'd194, 8'd0  }, '{8'd194, 8'd194, 8'd0  },
      '{8'd0,   8'd0,   8'd194}, '{8'd194, 8'd0,   8'd194}, '{8'd0,   8'd194, 8'd194},
      '{8'd255, 8'd0,   8'd0  }, '{8'd0,   8'd255, 8'd0  }, '{8'd255, 8'd255, 8'd0  },
      '{8'd0,   8'd0,   8'd255}, '{8'd255, 8'd0,   8'd255}, '{8'd0,   8'd255, 8'd255}
   };

endpackage

>>> rtl/pnm_rom.sv
`timescale 1ns / 1ps

module pnm_rom (
   input  logic                          clock,
   input  logic [pnm_pkg::IDX_W-1:0]     rd_addr,
   output pnm_pkg::row_type              rd_data
);

   localparam pnm_pkg::row_type MEM [pnm_pkg::ROM_ROWS] = pnm_pkg::PALETTE;

   pnm_pkg::row_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_addr < pnm_pkg::IDX_W'(pnm_pkg::ROM_ROWS)) begin
         rd_data_ff <= MEM[rd_addr];
      end else begin
         rd_data_ff <= '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/pnm_search.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pnm_search (
   input  logic                          clock,
   input  logic                          reset,
   input  pnm_pkg::ctl_type              ctl,
   input  pnm_pkg::row_type              row,
   input  logic [pnm_pkg::CH_W-1:0]      tgt_r,
   input  logic [pnm_pkg::CH_W-1:0]      tgt_g,
   input  logic [pnm_pkg::CH_W-1:0]      tgt_b,
   output logic                          busy,
   output logic [pnm_pkg::IDX_W-1:0]     pick,
   output logic                          light
);

   logic                          p1_valid_ff;
   logic [pnm_pkg::IDX_W-1:0]     p1_idx_ff;
   logic                          p2_valid_ff;
   logic [pnm_pkg::IDX_W-1:0]     p2_idx_ff;
   logic                          p2_ok_ff;
   logic [pnm_pkg::SQ_W-1:0]      sq_r_ff;
   logic [pnm_pkg::SQ_W-1:0]      sq_g_ff;
   logic [pnm_pkg::SQ_W-1:0]      sq_b_ff;
   logic [pnm_pkg::DIST_W-1:0]    best_ff;
   logic [pnm_pkg::IDX_W-1:0]     pick_ff;
   logic                          light_ff;

   logic                          ok;
   logic [pnm_pkg::CH_W-1:0]      dr;
   logic [pnm_pkg::CH_W-1:0]      dg;
   logic [pnm_pkg::CH_W-1:0]      db;
   logic [pnm_pkg::DIST_W-1:0]    sum_sq;

   // Stage 1: qualify the entry and square the channel gaps.
   always_comb begin
      ok = (row.r >= tgt_r) && (row.g >= tgt_g) && (row.b >= tgt_b);
      dr = row.r - tgt_r;
      dg = row.g - tgt_g;
      db = row.b - tgt_b;
   end

   // Stage 2: sum and compare against the running best.
   assign sum_sq = pnm_pkg::DIST_W'(sq_r_ff) + pnm_pkg::DIST_W'(sq_g_ff)
                 + pnm_pkg::DIST_W'(sq_b_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= ctl.issue;
         p2_valid_ff <= p1_valid_ff;
      end
      p1_idx_ff <= ctl.idx;
      p2_idx_ff <= p1_idx_ff;
      p2_ok_ff  <= ok;
      sq_r_ff   <= pnm_pkg::SQ_W'(dr) * pnm_pkg::SQ_W'(dr);
      sq_g_ff   <= pnm_pkg::SQ_W'(dg) * pnm_pkg::SQ_W'(dg);
      sq_b_ff   <= pnm_pkg::SQ_W'(db) * pnm_pkg::SQ_W'(db);
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         best_ff <= pnm_pkg::NO_MATCH_DIST;
         pick_ff <= pnm_pkg::BLACK_IDX;
      end else if (p2_valid_ff && p2_ok_ff && (sum_sq < best_ff)) begin
         best_ff <= sum_sq;
         pick_ff <= p2_idx_ff;
      end
      if (reset) begin
         light_ff <= 1'b0;
      end else if (p2_valid_ff) begin
         light_ff <= sum_sq > pnm_pkg::LIGHT_LIMIT;
      end
   end

   assign busy  = p1_valid_ff || p2_valid_ff;
   assign pick  = pick_ff;
   assign light = light_ff;

   `ASSERT_CLK(a_best_bound, clock, reset, best_ff <= pnm_pkg::NO_MATCH_DIST, "best above limit")
   `ASSERT_CLK(a_nomatch_black, clock, reset,
      (best_ff == pnm_pkg::NO_MATCH_DIST) |-> (pick_ff == pnm_pkg::BLACK_IDX),
      "pick set without a match")
   `ASSERT_CLK(a_pipe_follow, clock, reset, $past(p1_valid_ff) |-> p2_valid_ff,
      "stage 2 lost a beat")

endmodule

>>> rtl/palette_nearest_and_mix.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Palette lookup against a fixed 30-entry RGB ROM.
// Request channel (req_*): opcode 0 finds the nearest entry at or above the
// target color, opcode 1 mixes two entries, opcode 2 tests first_color for
// lightness. Each request beat yields exactly one response beat (rsp_*).
// Flow: nearest sweeps entries 0 to USED-1, where USED = min(PALETTE_SIZE, 30),
// through the one ROM read port, one entry per cycle, into the two-stage
// distance pipeline behind it; mix first fetches both entries from the ROM,
// ORs them into a target and sweeps for it, or skips the fetch and the sweep
// when either index is black; the lightness test sends first_color alone.
// One request is worked at a time; req_ready is high only while idle, so a
// new beat is taken in the cycle after the previous result is loaded.
// The response sits in an output register, so the next request is taken
// while a finished response still waits; a stalled rsp_ready holds that
// register and, once a further result is ready, holds the sequencer too.
// Reset is synchronous and empties the block; no clearing pass is needed.
module palette_nearest_and_mix #(
   parameter int PALETTE_SIZE = 30
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_opcode,
   input  logic [7:0]                    req_red,
   input  logic [7:0]                    req_green,
   input  logic [7:0]                    req_blue,
   input  logic [4:0]                    req_first_color,
   input  logic [4:0]                    req_second_color,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [4:0]                    rsp_color_index,
   output logic                          rsp_is_light
);

   localparam int USED = (PALETTE_SIZE < pnm_pkg::ROM_ROWS) ? PALETTE_SIZE
                                                             : pnm_pkg::ROM_ROWS;
   localparam logic [pnm_pkg::IDX_W-1:0] USED_IDX = pnm_pkg::IDX_W'(USED);
   localparam logic [pnm_pkg::IDX_W-1:0] LAST_IDX = pnm_pkg::IDX_W'(USED - 1);

   localparam logic [1:0] FETCH_A = 2'd0;
   localparam logic [1:0] FETCH_B = 2'd1;

   pnm_pkg::state_type            state_ff, state_in;
   logic [pnm_pkg::IDX_W-1:0]     cnt_ff, cnt_in;
   pnm_pkg::op_type               op_ff, op_in;
   logic [pnm_pkg::IDX_W-1:0]     c1_ff, c1_in;
   logic [pnm_pkg::IDX_W-1:0]     c2_ff, c2_in;
   logic [pnm_pkg::CH_W-1:0]      tgt_r_ff, tgt_r_in;
   logic [pnm_pkg::CH_W-1:0]      tgt_g_ff, tgt_g_in;
   logic [pnm_pkg::CH_W-1:0]      tgt_b_ff, tgt_b_in;
   pnm_pkg::row_type              mix_ff, mix_in;
   logic [pnm_pkg::IDX_W-1:0]     res_idx_ff, res_idx_in;
   logic                          res_light_ff, res_light_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [pnm_pkg::IDX_W-1:0]     rsp_idx_ff, rsp_idx_in;
   logic                          rsp_light_ff, rsp_light_in;

   logic [pnm_pkg::IDX_W-1:0]     rd_addr;
   pnm_pkg::row_type              row;
   pnm_pkg::ctl_type              ctl;
   logic                          busy;
   logic [pnm_pkg::IDX_W-1:0]     pick;
   logic                          light;
   logic [pnm_pkg::IDX_W-1:0]     c1_clamp;
   logic [pnm_pkg::IDX_W-1:0]     c2_clamp;
   logic                          load_rsp;

   pnm_rom u_rom (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_data (row)
   );

   pnm_search u_search (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .row   (row),
      .tgt_r (tgt_r_ff),
      .tgt_g (tgt_g_ff),
      .tgt_b (tgt_b_ff),
      .busy  (busy),
      .pick  (pick),
      .light (light)
   );

   // Out-of-range indices read as black.
   assign c1_clamp = (req_first_color < USED_IDX) ? req_first_color : pnm_pkg::BLACK_IDX;
   assign c2_clamp = (req_second_color < USED_IDX) ? req_second_color : pnm_pkg::BLACK_IDX;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      op_in        = op_ff;
      c1_in        = c1_ff;
      c2_in        = c2_ff;
      tgt_r_in     = tgt_r_ff;
      tgt_g_in     = tgt_g_ff;
      tgt_b_in     = tgt_b_ff;
      mix_in       = mix_ff;
      res_idx_in   = res_idx_ff;
      res_light_in = res_light_ff;
      rd_addr      = cnt_ff;
      ctl          = '0;
      req_ready    = 1'b0;
      load_rsp     = 1'b0;

      unique case (state_ff)
         pnm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in        = pnm_pkg::op_type'(req_opcode);
               c1_in        = c1_clamp;
               c2_in        = c2_clamp;
               cnt_in       = '0;
               res_light_in = 1'b0;
               unique case (pnm_pkg::op_type'(req_opcode))
                  pnm_pkg::OP_NEAREST: begin
                     tgt_r_in  = req_red;
                     tgt_g_in  = req_green;
                     tgt_b_in  = req_blue;
                     ctl.clear = 1'b1;
                     state_in  = pnm_pkg::ST_SCAN;
                  end
                  pnm_pkg::OP_MIX: begin
                     priority if (c1_clamp == pnm_pkg::BLACK_IDX) begin
                        res_idx_in = c2_clamp;
                        state_in   = pnm_pkg::ST_DONE;
                     end else if (c2_clamp == pnm_pkg::BLACK_IDX) begin
                        res_idx_in = c1_clamp;
                        state_in   = pnm_pkg::ST_DONE;
                     end else begin
                        state_in   = pnm_pkg::ST_FETCH;
                     end
                  end
                  pnm_pkg::OP_LIGHT: begin
                     // Distance to black is the sum of squares.
                     tgt_r_in = '0;
                     tgt_g_in = '0;
                     tgt_b_in = '0;
                     state_in = pnm_pkg::ST_LIGHT;
                  end
                  default: begin
                     res_idx_in = pnm_pkg::BLACK_IDX;
                     state_in   = pnm_pkg::ST_DONE;
                  end
               endcase
            end
         end
         pnm_pkg::ST_FETCH: begin
            rd_addr = (cnt_ff[1:0] == FETCH_A) ? c1_ff : c2_ff;
            cnt_in  = cnt_ff + pnm_pkg::IDX_W'(1);
            if (cnt_ff[1:0] == FETCH_B) begin
               mix_in = row;
            end else if (cnt_ff[1:0] != FETCH_A) begin
               // Second row is out; OR both into the target.
               tgt_r_in  = mix_ff.r | row.r;
               tgt_g_in  = mix_ff.g | row.g;
               tgt_b_in  = mix_ff.b | row.b;
               ctl.clear = 1'b1;
               cnt_in    = '0;
               state_in  = pnm_pkg::ST_SCAN;
            end
         end
         pnm_pkg::ST_SCAN: begin
            rd_addr   = cnt_ff;
            ctl.issue = 1'b1;
            ctl.idx   = cnt_ff;
            if (cnt_ff == LAST_IDX) begin
               cnt_in   = '0;
               state_in = pnm_pkg::ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + pnm_pkg::IDX_W'(1);
            end
         end
         pnm_pkg::ST_LIGHT: begin
            rd_addr   = c1_ff;
            ctl.issue = 1'b1;
            ctl.idx   = c1_ff;
            state_in  = pnm_pkg::ST_DRAIN;
         end
         pnm_pkg::ST_DRAIN: begin
            if (!busy) begin
               state_in = pnm_pkg::ST_DONE;
               unique case (op_ff)
                  pnm_pkg::OP_NEAREST: res_idx_in = pick;
                  pnm_pkg::OP_MIX: begin
                     res_idx_in = (pick == pnm_pkg::BLACK_IDX) ? pnm_pkg::DDGRAY_IDX : pick;
                  end
                  pnm_pkg::OP_LIGHT: begin
                     res_idx_in   = pnm_pkg::BLACK_IDX;
                     res_light_in = light;
                  end
                  default: res_idx_in = pnm_pkg::BLACK_IDX;
               endcase
            end
         end
         pnm_pkg::ST_DONE: begin
            // Hold until the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = pnm_pkg::ST_IDLE;
            end
         end
         default: state_in = pnm_pkg::ST_IDLE;
      endcase

      rsp_idx_in   = load_rsp ? res_idx_ff : rsp_idx_ff;
      rsp_light_in = load_rsp ? res_light_ff : rsp_light_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pnm_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      c1_ff        <= c1_in;
      c2_ff        <= c2_in;
      tgt_r_ff     <= tgt_r_in;
      tgt_g_ff     <= tgt_g_in;
      tgt_b_ff     <= tgt_b_in;
      mix_ff       <= mix_in;
      res_idx_ff   <= res_idx_in;
      res_light_ff <= res_light_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_light_ff <= rsp_light_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_color_index = rsp_idx_ff;
   assign rsp_is_light    = rsp_light_ff;

   `ASSERT_CLK(a_done_issues, clock, reset,
      (state_ff == pnm_pkg::ST_DONE && (!rsp_valid_ff || rsp_ready)) |=> rsp_valid,
      "finished result not presented")
   `ASSERT_CLK(a_idx_range, clock, reset, rsp_valid |-> (rsp_color_index < USED_IDX),
      "response index beyond palette")
   `ASSERT_NEVER(a_light_idx, clock, reset,
      rsp_valid && rsp_is_light && (rsp_color_index != pnm_pkg::BLACK_IDX),
      "light flag with nonzero index")

endmodule

>>> bench/palette_nearest_and_mix_test.sv
`timescale 1ns / 1ps

module palette_nearest_and_mix_test;
   import pnm_pkg::*;

   typedef struct {
      op_type     op;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [4:0] first_color;
      logic [4:0] second_color;
   } lookup_req;

   typedef struct {
      logic [4:0] color_index;
      logic       is_light;
   } lookup_rsp;

   localparam int USED_ENTRIES  = ROM_ROWS;
   localparam int RANDOM_PER_PHASE = 300;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 60;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_opcode = 2'd0;
   logic [7:0] req_red = 8'd0;
   logic [7:0] req_green = 8'd0;
   logic [7:0] req_blue = 8'd0;
   logic [4:0] req_first_color = 5'd0;
   logic [4:0] req_second_color = 5'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [4:0] rsp_color_index;
   logic       rsp_is_light;

   lookup_req pending_requests[$];
   lookup_rsp expected_results[$];
   int        mismatches = 0;
   int        sender_idle_pct = 0;
   int        receiver_stall_pct = 0;
   logic      hold_trigger = 1'b0;
   int        hold_left = 0;

   palette_nearest_and_mix u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_red          (req_red),
      .req_green        (req_green),
      .req_blue         (req_blue),
      .req_first_color  (req_first_color),
      .req_second_color (req_second_color),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_color_index  (rsp_color_index),
      .rsp_is_light     (rsp_is_light)
   );

   always #5 clock = ~clock;

   // Smallest squared distance among entries that dominate the target on
   // every channel; lowest index wins a tie, black when nothing qualifies.
   function automatic logic [4:0] nearest_entry(int r, int g, int b);
      int best;
      int pick;
      int cr, cg, cb, d;
      best = 255 * 255 * 3 + 1;
      pick = int'(BLACK_IDX);
      for (int i = 0; i < USED_ENTRIES; i++) begin
         cr = PALETTE[i].r;
         cg = PALETTE[i].g;
         cb = PALETTE[i].b;
         if (cr >= r && cg >= g && cb >= b) begin
            d = (cr - r) * (cr - r) + (cg - g) * (cg - g) + (cb - b) * (cb - b);
            if (d < best) begin
               best = d;
               pick = i;
            end
         end
      end
      return 5'(pick);
   endfunction

   function automatic int palette_slot(logic [4:0] idx);
      return (int'(idx) < USED_ENTRIES) ? int'(idx) : int'(BLACK_IDX);
   endfunction

   function automatic logic [4:0] mix_entries(int a, int c);
      logic [4:0] n;
      if (a == int'(BLACK_IDX)) return 5'(c);
      if (c == int'(BLACK_IDX)) return 5'(a);
      n = nearest_entry(int'(PALETTE[a].r | PALETTE[c].r),
                        int'(PALETTE[a].g | PALETTE[c].g),
                        int'(PALETTE[a].b | PALETTE[c].b));
      return (n == BLACK_IDX) ? DDGRAY_IDX : n;
   endfunction

   function automatic lookup_rsp predict_lookup(lookup_req q);
      lookup_rsp res;
      int a, c, r, g, b;
      a = palette_slot(q.first_color);
      c = palette_slot(q.second_color);
      res.color_index = '0;
      res.is_light = 1'b0;
      case (q.op)
         OP_NEAREST: res.color_index = nearest_entry(q.red, q.green, q.blue);
         OP_MIX:     res.color_index = mix_entries(a, c);
         OP_LIGHT: begin
            r = PALETTE[a].r;
            g = PALETTE[a].g;
            b = PALETTE[a].b;
            res.is_light = (r * r + g * g + b * b > int'(LIGHT_LIMIT));
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic lookup_req make_req(op_type op, int r, int g, int b, int c1, int c2);
      lookup_req q;
      q.op = op;
      q.red = 8'(r);
      q.green = 8'(g);
      q.blue = 8'(b);
      q.first_color = 5'(c1);
      q.second_color = 5'(c2);
      return q;
   endfunction

   function automatic int random_color_index();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                         : $urandom_range(0, USED_ENTRIES - 1);
   endfunction

   function automatic lookup_req random_req();
      lookup_req q;
      int sel, e, k;
      sel = $urandom_range(0, 99);
      q = make_req(OP_NONE, $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255), random_color_index(), random_color_index());
      if (sel < 40) begin
         q.op = OP_NEAREST;
         k = $urandom_range(0, 3);
         e = $urandom_range(0, USED_ENTRIES - 1);
         // aim at or just below a palette color to hit exact matches and ties
         if (k == 0) begin
            q.red = PALETTE[e].r;
            q.green = PALETTE[e].g;
            q.blue = PALETTE[e].b;
         end else if (k == 1) begin
            q.red = (PALETTE[e].r > 8'd3) ? PALETTE[e].r - 8'($urandom_range(0, 3)) : 8'd0;
            q.green = (PALETTE[e].g > 8'd3) ? PALETTE[e].g - 8'($urandom_range(0, 3)) : 8'd0;
            q.blue = (PALETTE[e].b > 8'd3) ? PALETTE[e].b - 8'($urandom_range(0, 3)) : 8'd0;
         end
      end else if (sel < 70) begin
         q.op = OP_MIX;
      end else if (sel < 92) begin
         q.op = OP_LIGHT;
      end
      return q;
   endfunction

   task automatic load_directed();
      pending_requests.push_back(make_req(OP_NEAREST, 0, 0, 0, 31, 31));
      pending_requests.push_back(make_req(OP_NEAREST, 255, 255, 255, 0, 0));
      pending_requests.push_back(make_req(OP_NEAREST, 1, 1, 1, 5, 9));
      pending_requests.push_back(make_req(OP_NEAREST, 255, 0, 0, 0, 0));
      pending_requests.push_back(make_req(OP_NEAREST, 0, 0, 255, 0, 0));
      pending_requests.push_back(make_req(OP_NEAREST, 133, 72, 0, 0, 0));
      pending_requests.push_back(make_req(OP_NEAREST, 195, 195, 195, 0, 0));
      pending_requests.push_back(make_req(OP_NEAREST, 128, 128, 128, 0, 0));
      pending_requests.push_back(make_req(OP_MIX, 0, 0, 0, 0, 5));
      pending_requests.push_back(make_req(OP_MIX, 255, 255, 255, 7, 0));
      pending_requests.push_back(make_req(OP_MIX, 0, 0, 0, 0, 0));
      pending_requests.push_back(make_req(OP_MIX, 0, 0, 0, 6, 7));
      pending_requests.push_back(make_req(OP_MIX, 0, 0, 0, 29, 24));
      pending_requests.push_back(make_req(OP_MIX, 0, 0, 0, 30, 12));
      pending_requests.push_back(make_req(OP_MIX, 0, 0, 0, 13, 31));
      pending_requests.push_back(make_req(OP_MIX, 0, 0, 0, 1, 3));
      pending_requests.push_back(make_req(OP_LIGHT, 255, 255, 255, 0, 4));
      pending_requests.push_back(make_req(OP_LIGHT, 0, 0, 0, 4, 0));
      pending_requests.push_back(make_req(OP_LIGHT, 0, 0, 0, 2, 0));
      pending_requests.push_back(make_req(OP_LIGHT, 0, 0, 0, 1, 0));
      pending_requests.push_back(make_req(OP_LIGHT, 0, 0, 0, 29, 31));
      pending_requests.push_back(make_req(OP_LIGHT, 0, 0, 0, 31, 0));
      pending_requests.push_back(make_req(OP_NONE, 255, 255, 255, 31, 31));
      pending_requests.push_back(make_req(OP_NONE, 0, 0, 0, 4, 4));
   endtask

   task automatic wait_drained();
      while (pending_requests.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
   endtask

   // Request driver: hold the beat until accepted, then advance or idle.
   always @(posedge clock) begin
      lookup_req q;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            q = make_req(op_type'(req_opcode), req_red, req_green, req_blue,
                         req_first_color, req_second_color);
            expected_results.push_back(predict_lookup(q));
         end
         if (!req_valid || req_ready) begin
            if (pending_requests.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               q = pending_requests.pop_front();
               req_opcode <= q.op;
               req_red <= q.red;
               req_green <= q.green;
               req_blue <= q.blue;
               req_first_color <= q.first_color;
               req_second_color <= q.second_color;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long back-pressure window, counted down on its own.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_trigger) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   // Response monitor: compare each beat with the oldest prediction.
   always @(posedge clock) begin
      lookup_rsp want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            if (mismatches < 10)
               $display("ERROR: unexpected response color_index=%0d is_light=%0d",
                        rsp_color_index, rsp_is_light);
            mismatches++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_color_index !== want.color_index || rsp_is_light !== want.is_light) begin
               if (mismatches < 10)
                  $display("ERROR: color_index exp %0d got %0d, is_light exp %0d got %0d",
                           want.color_index, rsp_color_index, want.is_light, rsp_is_light);
               mismatches++;
            end
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < 4; phase++) begin
         @(posedge clock);
         case (phase)
            0: begin sender_idle_pct <= 0;  receiver_stall_pct <= 0;  end
            1: begin sender_idle_pct <= 76; receiver_stall_pct <= 0;  end
            2: begin sender_idle_pct <= 0;  receiver_stall_pct <= 76; end
            default: begin sender_idle_pct <= 34; receiver_stall_pct <= 34; end
         endcase
         if (phase == 0) load_directed();
         for (int i = 0; i < RANDOM_PER_PHASE; i++)
            pending_requests.push_back(random_req());
         if (phase == 0) begin
            // stall the receiver while requests keep coming
            repeat (40) @(posedge clock);
            hold_trigger <= 1'b1;
            @(posedge clock);
            hold_trigger <= 1'b0;
         end
         wait_drained();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/pnm_pkg.sv
rtl/pnm_rom.sv
rtl/pnm_search.sv
rtl/palette_nearest_and_mix.sv
bench/palette_nearest_and_mix_test.sv
